// File: rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg - shared types and constants of the typed frame deframer
// Field widths, result codes and the Adler-32 modulus.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 31;

    localparam logic [15:0] ADLER_MOD = 16'd65521;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    // byte_kind codes
    localparam kind_t KIND_NAME    = 2'd0;
    localparam kind_t KIND_PAYLOAD = 2'd1;
    localparam kind_t KIND_NONE    = 2'd2;

    // status codes
    localparam status_t ST_BUSY     = 3'd0;
    localparam status_t ST_OK       = 3'd1;
    localparam status_t ST_BAD_LEN  = 3'd2;
    localparam status_t ST_BAD_SUM  = 3'd3;
    localparam status_t ST_BAD_TYPE = 3'd4;

    // configuration register indexes
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // running Adler-32 halves
    typedef struct packed {
        logic [15:0] low;
        logic [15:0] high;
    } adler_t;

endpackage : tfd_pkg

`default_nettype wire

// File: rtl/tfd_ifs.sv
// ----------------------------------------------------------------------------
// tfd_ifs - request channels of the typed frame deframer
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfd_in_if
    import tfd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface : tfd_in_if

interface tfd_out_if
    import tfd_pkg::*;
();
    logic    valid;
    logic    ready;
    byte_t   out_byte;
    kind_t   byte_kind;
    logic    frame_end;
    status_t status;

    modport source (output valid, output out_byte, output byte_kind, output frame_end,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input frame_end,
                    input status, output ready);
endinterface : tfd_out_if

`default_nettype wire

// File: rtl/tfd_adler.sv
// ----------------------------------------------------------------------------
// tfd_adler - one-byte Adler-32 update
// Adds a byte into both running sums, each reduced by one conditional subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_adler
    import tfd_pkg::*;
(
    input  adler_t sum,
    input  byte_t  data,
    output adler_t sum_next
);

    logic [16:0] low_raw;
    logic [16:0] high_raw;
    logic [15:0] low_mod;

    // low < MOD and data < 256, so one subtract is enough
    assign low_raw  = {1'b0, sum.low} + {9'd0, data};
    assign low_mod  = (low_raw >= {1'b0, ADLER_MOD}) ? 16'(low_raw - {1'b0, ADLER_MOD})
                                                      : low_raw[15:0];
    assign high_raw = {1'b0, sum.high} + {1'b0, low_mod};

    assign sum_next.low  = low_mod;
    assign sum_next.high = (high_raw >= {1'b0, ADLER_MOD}) ? 16'(high_raw - {1'b0, ADLER_MOD})
                                                            : high_raw[15:0];

endmodule : tfd_adler

`default_nettype wire

// File: rtl/typed_frame_deframer_adler32.sv
// ----------------------------------------------------------------------------
// typed_frame_deframer_adler32 - length-prefixed frame deframer, Adler-32 check
//
// Usage:
//   stream  : one received byte per request (valid/ready).
//   result  : name bytes, payload bytes and one status request per frame.
//   cfg_*   : write port for min/max frame length; write only while idle.
// Frame: 32-bit big-endian length L, L-4 content bytes (32-bit type length,
// name, NUL, payload), then a big-endian Adler-32 of the content.
// Path: an accepted byte goes into the input register, and its result, if any,
// into the result register. Throughput: one byte per cycle unless stalled;
// the state update per byte is one Adler add pair and a counter compare.
// Stall: the input register holds while the result register is full and not
// taken; stream.ready drops only then, so a stalled receiver backs up to
// the byte source without losing anything.
// Reset: state goes to waiting for a length field, registers to defaults
// (min 10, max 64 Mi). A bad length or checksum closes the link: bytes are
// still consumed but produce nothing until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_frame_deframer_adler32
    import tfd_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    tfd_in_if.sink     stream,
    tfd_out_if.source  result,
    input  wire        cfg_we,
    input  wire        cfg_index,
    input  wire cfg_t  cfg_data
);

    // frame phase codes
    localparam logic [1:0] PH_LEN     = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_SUM     = 2'd2;

    // configuration
    cfg_t min_len_reg;
    cfg_t max_len_reg;

    // input register
    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_adv;

    // frame state
    logic [1:0]  phase_reg,      phase_next;
    logic [31:0] frame_len_reg,  frame_len_next;
    logic [31:0] clen_reg,       clen_next;      // content length L-4
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] name_len_reg,   name_len_next;
    logic [31:0] nul_idx_reg,    nul_idx_next;   // content index of the NUL
    logic        tl_ok_reg,      tl_ok_next;     // type length valid for this frame
    logic [31:0] rx_sum_reg,     rx_sum_next;
    logic        closed_reg,     closed_next;
    adler_t      adler_reg,      adler_next;
    adler_t      adler_upd;

    // result register
    logic    out_valid_reg;
    byte_t   out_byte_reg;
    kind_t   out_kind_reg;
    logic    out_end_reg;
    status_t out_status_reg;

    // result of the byte in the input register
    logic    res_valid;
    kind_t   res_kind;
    logic    res_end;
    status_t res_status;

    // scratch
    logic [31:0] fl_full;
    logic [31:0] nl_full;
    logic [31:0] count_inc;
    logic        len_bad;

    tfd_adler u_adler (
        .sum      (adler_reg),
        .data     (s1_byte_reg),
        .sum_next (adler_upd)
    );

    // the input register moves on whenever the result register is free or drains
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || s1_adv;

    assign fl_full   = {frame_len_reg[23:0], s1_byte_reg};
    assign nl_full   = {name_len_reg[23:0], s1_byte_reg};
    assign count_inc = byte_count_reg + 32'd1;
    assign len_bad   = fl_full[31] || (fl_full[30:0] < min_len_reg) ||
                       (fl_full[30:0] > max_len_reg) || (fl_full < 32'd4);

    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        clen_next       = clen_reg;
        byte_count_next = byte_count_reg;
        name_len_next   = name_len_reg;
        nul_idx_next    = nul_idx_reg;
        tl_ok_next      = tl_ok_reg;
        rx_sum_next     = rx_sum_reg;
        closed_next     = closed_reg;
        adler_next      = adler_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_NONE;
        res_end         = 1'b0;
        res_status      = ST_BUSY;

        if (!closed_reg)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    frame_len_next  = fl_full;
                    byte_count_next = count_inc;
                    if (byte_count_reg[1:0] == 2'd3)
                    begin
                        byte_count_next = '0;
                        clen_next       = fl_full - 32'd4;
                        if (len_bad)
                        begin
                            closed_next = 1'b1;
                            res_valid   = 1'b1;
                            res_end     = 1'b1;
                            res_status  = ST_BAD_LEN;
                        end
                        else
                        begin
                            phase_next = (fl_full == 32'd4) ? PH_SUM : PH_CONTENT;
                        end
                    end
                end

                PH_CONTENT:
                begin
                    adler_next = adler_upd;
                    if (byte_count_reg[31:2] == '0)
                    begin
                        name_len_next = nl_full;
                        if (byte_count_reg[1:0] == 2'd3)
                        begin
                            // clen >= 4 here, so clen-4 = L-8 does not wrap
                            tl_ok_next   = (frame_len_reg >= 32'd8) && (nl_full != '0) &&
                                           !nl_full[31] && (nl_full <= clen_reg - 32'd4);
                            nul_idx_next = nl_full + 32'd3;
                        end
                    end
                    else if (tl_ok_reg)
                    begin
                        if (byte_count_reg < nul_idx_reg)
                        begin
                            res_valid = 1'b1;
                            res_kind  = KIND_NAME;
                        end
                        else if (byte_count_reg > nul_idx_reg)
                        begin
                            res_valid = 1'b1;
                            res_kind  = KIND_PAYLOAD;
                        end
                    end

                    byte_count_next = count_inc;
                    if (count_inc >= clen_reg)
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_SUM;
                    end
                end

                PH_SUM:
                begin
                    rx_sum_next     = {rx_sum_reg[23:0], s1_byte_reg};
                    byte_count_next = count_inc;
                    if (byte_count_reg[1:0] == 2'd3)
                    begin
                        res_valid = 1'b1;
                        res_end   = 1'b1;
                        priority if ({adler_reg.high, adler_reg.low} !=
                                     {rx_sum_reg[23:0], s1_byte_reg})
                        begin
                            closed_next = 1'b1;
                            res_status  = ST_BAD_SUM;
                        end
                        else if (!tl_ok_reg)
                        begin
                            res_status = ST_BAD_TYPE;
                        end
                        else
                        begin
                            res_status = ST_OK;
                        end
                        // start the next frame
                        phase_next      = PH_LEN;
                        byte_count_next = '0;
                        tl_ok_next      = 1'b0;
                        adler_next.low  = 16'd1;
                        adler_next.high = 16'd0;
                    end
                end

                default:
                begin
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 31'd10;
            max_len_reg <= 31'd67108864;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_LEN: min_len_reg <= cfg_data;
                CFG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg <= stream.in_byte;
        end
    end

    // frame state, updated as each byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            frame_len_reg  <= '0;
            clen_reg       <= '0;
            byte_count_reg <= '0;
            name_len_reg   <= '0;
            nul_idx_reg    <= '0;
            tl_ok_reg      <= 1'b0;
            rx_sum_reg     <= '0;
            closed_reg     <= 1'b0;
            adler_reg.low  <= 16'd1;
            adler_reg.high <= 16'd0;
        end
        else if (s1_adv)
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            clen_reg       <= clen_next;
            byte_count_reg <= byte_count_next;
            name_len_reg   <= name_len_next;
            nul_idx_reg    <= nul_idx_next;
            tl_ok_reg      <= tl_ok_next;
            rx_sum_reg     <= rx_sum_next;
            closed_reg     <= closed_next;
            adler_reg      <= adler_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= res_valid;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            out_byte_reg   <= (res_kind == KIND_NONE) ? 8'd0 : s1_byte_reg;
            out_kind_reg   <= res_kind;
            out_end_reg    <= res_end;
            out_status_reg <= res_status;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_byte  = out_byte_reg;
    assign result.byte_kind = out_kind_reg;
    assign result.frame_end = out_end_reg;
    assign result.status    = out_status_reg;

    // a closed link stays closed until reset
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("link reopened without reset");

    // a data-less result is always a frame end
    a_none_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.byte_kind == KIND_NONE) |-> result.frame_end)
        else $error("status result without frame end");

    // data bytes carry the busy status
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.frame_end) |->
            (result.status == ST_BUSY && result.byte_kind != KIND_NONE))
        else $error("data byte with final status");

    // checksum sums stay reduced
    a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
        (adler_reg.low < ADLER_MOD) && (adler_reg.high < ADLER_MOD))
        else $error("adler sum out of range");

    // a new frame starts with a fresh checksum
    a_adler_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN) |-> (adler_reg.low == 16'd1 && adler_reg.high == 16'd0))
        else $error("adler not restarted");

endmodule : typed_frame_deframer_adler32

`default_nettype wire

// File: tb/typed_frame_deframer_adler32_test.sv
// ----------------------------------------------------------------------------
// typed_frame_deframer_adler32_test - self-checking bench for the deframer
// Builds length-prefixed frames with a type length, name, NUL, payload and
// Adler-32 trailer. A directed table runs first, then random frames under
// random length limits. A byte-level model of the deframer predicts every
// result request, and the output channel is compared field by field. Both
// channels idle at random. The run ends by closing the link on purpose.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_frame_deframer_adler32_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 80;
    localparam int HDR          = 4;     // length field and trailer are 4 bytes

    typedef enum logic [1:0] {PH_LENGTH, PH_BODY, PH_CHECK} phase_t;
    typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_t;

    // one result request as the deframer should produce it
    typedef struct packed {
        byte_t   data;
        kind_t   kind;
        logic    fin;
        status_t st;
    } result_t;

    // directed row: a frame (len, tlen), or a limit write (len = min, tlen = max)
    typedef struct {
        row_kind_t   kind;
        logic [31:0] len;
        logic [31:0] tlen;
        fill_t       fill;
        status_t     want;   // ST_BUSY: leave the closing status to the model
    } row_t;

    row_t plan [0:16] = '{
        '{ROW_FRAME,  32'd12,  32'd3,          FILL_RAND, ST_OK},       // short name, 1 payload byte
        '{ROW_FRAME,  32'd10,  32'd1,          FILL_RAND, ST_OK},       // L at reset min, empty name
        '{ROW_FRAME,  32'd16,  32'd8,          FILL_ONES, ST_OK},       // name fills content
        '{ROW_FRAME,  32'd16,  32'd9,          FILL_ZERO, ST_BAD_TYPE}, // T one past the frame
        '{ROW_FRAME,  32'd12,  32'd0,          FILL_RAND, ST_BAD_TYPE}, // T zero
        '{ROW_FRAME,  32'd12,  32'h8000_0001,  FILL_RAND, ST_BAD_TYPE}, // T negative
        '{ROW_FRAME,  32'd10,  32'hFFFF_FFFF,  FILL_ONES, ST_BAD_TYPE}, // T all ones
        '{ROW_CONFIG, 32'd0,   32'h7FFF_FFFF,  FILL_RAND, ST_BUSY},     // widest limits
        '{ROW_FRAME,  32'd4,   32'd0,          FILL_RAND, ST_BAD_TYPE}, // no content at all
        '{ROW_FRAME,  32'd6,   32'd1,          FILL_RAND, ST_BAD_TYPE}, // content shorter than the T field
        '{ROW_FRAME,  32'd7,   32'h0102_0304,  FILL_RAND, ST_BAD_TYPE},
        '{ROW_FRAME,  32'd8,   32'd0,          FILL_RAND, ST_BAD_TYPE}, // only T, nothing after
        '{ROW_FRAME,  32'd9,   32'd1,          FILL_ONES, ST_OK},       // NUL only, nonzero value
        '{ROW_FRAME,  32'd268, 32'd40,         FILL_ONES, ST_OK},       // both Adler sums wrap
        '{ROW_FRAME,  32'd24,  32'd12,         FILL_ZERO, ST_OK},
        '{ROW_CONFIG, 32'd10,  32'd67108864,   FILL_RAND, ST_BUSY},     // back to reset limits
        '{ROW_FRAME,  32'd24,  32'd5,          FILL_RAND, ST_BUSY}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    cfg_t cfg_data;

    tfd_in_if  stream_if ();
    tfd_out_if result_if ();

    typed_frame_deframer_adler32 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // deframer model state (mirrors the block's own registers)
    // ------------------------------------------------------------------
    phase_t      frame_phase;
    logic [31:0] len_field;
    logic [31:0] pos;
    logic [31:0] type_len;
    adler_t      run_sum;
    logic [31:0] sum_field;
    logic        link_closed;
    cfg_t        min_len;
    cfg_t        max_len;

    result_t     pending_results[$];  // result requests still owed by the block
    byte_t       frame_bytes[$];      // stream bytes of the frame being built
    status_t     status_override;     // typed-in closing status of a table row

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned results_seen;
    bit          calm;                // no idling on either side while set

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: generous multiple of the slowest legal run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Adler-32 running update, one byte
    function automatic adler_t adler_add(input adler_t s, input byte_t b);
        adler_t      n;
        int unsigned t;
        t      = (32'(s.low) + 32'(b)) % 32'(ADLER_MOD);
        n.low  = t[15:0];
        t      = (32'(s.high) + 32'(n.low)) % 32'(ADLER_MOD);
        n.high = t[15:0];
        return n;
    endfunction

    // T is usable only when the name and the NUL fit in the content after the T field
    function automatic bit type_len_valid();
        if (len_field < 32'd8 || type_len == 32'd0 || type_len[31])
            return 1'b0;
        return type_len <= len_field - 32'd8;
    endfunction

    task automatic clear_frame();
        frame_phase = PH_LENGTH;
        len_field   = '0;
        pos         = '0;
        type_len    = '0;
        run_sum     = '{low: 16'd1, high: 16'd0};
        sum_field   = '0;
    endtask

    // Advance the model by one accepted stream byte; queue what it must emit.
    task automatic deframe_byte(input byte_t b);
        result_t     r;
        bit          hit;
        logic [31:0] off;
        hit = 1'b0;
        r   = '{data: 8'h00, kind: KIND_NONE, fin: 1'b1, st: ST_BUSY};
        if (link_closed)
            return;
        case (frame_phase)
            PH_LENGTH:
            begin
                len_field = {len_field[23:0], b};
                pos++;
                if (pos == HDR)
                begin
                    pos = '0;
                    // L is signed: bit 31 set means negative and always bad
                    if (len_field[31] || len_field < 32'(min_len) ||
                        len_field > 32'(max_len) || len_field < HDR)
                    begin
                        link_closed = 1'b1;
                        hit         = 1'b1;
                        r.st        = ST_BAD_LEN;
                    end
                    else
                        frame_phase = (len_field == HDR) ? PH_CHECK : PH_BODY;
                end
            end
            PH_BODY:
            begin
                run_sum = adler_add(run_sum, b);
                if (pos < HDR)
                    type_len = {type_len[23:0], b};
                else if (type_len_valid())
                begin
                    off = pos - HDR;
                    // the byte at the NUL slot is dropped whatever it holds
                    if (off != type_len - 32'd1)
                    begin
                        hit    = 1'b1;
                        r.data = b;
                        r.kind = (off < type_len - 32'd1) ? KIND_NAME : KIND_PAYLOAD;
                        r.fin  = 1'b0;
                    end
                end
                pos++;
                if (pos >= len_field - HDR)
                begin
                    pos         = '0;
                    frame_phase = PH_CHECK;
                end
            end
            default:
            begin
                sum_field = {sum_field[23:0], b};
                pos++;
                if (pos == HDR)
                begin
                    hit = 1'b1;
                    // checksum beats the type length check, and closes the link
                    if ({run_sum.high, run_sum.low} != sum_field)
                    begin
                        link_closed = 1'b1;
                        r.st        = ST_BAD_SUM;
                    end
                    else if (!type_len_valid())
                        r.st = ST_BAD_TYPE;
                    else
                        r.st = ST_OK;
                    clear_frame();
                end
            end
        endcase
        if (hit)
        begin
            if (r.fin && status_override != ST_BUSY)
                r.st = status_override;
            pending_results.push_back(r);
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Frame into frame_bytes; header_only leaves just the length field.
    task automatic build_frame(input logic [31:0] flen, input logic [31:0] tlen,
                               input fill_t fill, input bit sum_ok,
                               input bit header_only);
        adler_t      acc;
        logic [31:0] trailer;
        byte_t       c;
        frame_bytes.delete();
        for (int i = 0; i < HDR; i++)
            frame_bytes.push_back(flen[31 - 8 * i -: 8]);
        if (header_only)
            return;
        acc = '{low: 16'd1, high: 16'd0};
        for (int unsigned i = 0; i < flen - HDR; i++)
        begin
            if (i < HDR)
                c = tlen[31 - 8 * i -: 8];
            else if (fill == FILL_ZERO)
                c = 8'h00;
            else if (fill == FILL_ONES)
                c = 8'hFF;
            else
                c = 8'($urandom);
            frame_bytes.push_back(c);
            acc = adler_add(acc, c);
        end
        trailer = {acc.high, acc.low};
        if (!sum_ok)
            trailer ^= ($urandom | 32'h1);
        for (int i = 0; i < HDR; i++)
            frame_bytes.push_back(trailer[31 - 8 * i -: 8]);
    endtask

    // One stream request; valid stays up so back-to-back bytes need no toggle.
    task automatic send_byte(input byte_t b);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid   <= 1'b1;
        stream_if.in_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frames_sent++;
    endtask

    // Hold the sender until every owed result is in, then cover the pipeline
    // (two register stages) so a byte with no result is not still in flight.
    task automatic settle();
        stream_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Both limits, back to back; only call after settle().
    task automatic write_limits(input cfg_t lo, input cfg_t hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_LEN;
        cfg_data  <= lo;
        @(posedge clk);
        min_len    = lo;
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= hi;
        @(posedge clk);
        max_len = hi;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard compare
    // ------------------------------------------------------------------
    int unsigned stall_left;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report($sformatf("unexpected result byte=%02h kind=%0d end=%0b status=%0d",
                                 result_if.out_byte, result_if.byte_kind,
                                 result_if.frame_end, result_if.status));
            else
            begin
                want = pending_results.pop_front();
                if (result_if.out_byte !== want.data)
                    report($sformatf("out_byte %02h, want %02h",
                                     result_if.out_byte, want.data));
                if (result_if.byte_kind !== want.kind)
                    report($sformatf("byte_kind %0d, want %0d",
                                     result_if.byte_kind, want.kind));
                if (result_if.frame_end !== want.fin)
                    report($sformatf("frame_end %0b, want %0b",
                                     result_if.frame_end, want.fin));
                if (result_if.status !== want.st)
                    report($sformatf("status %0d, want %0d",
                                     result_if.status, want.st));
            end
        end
        if (calm)
            result_if.ready <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left--;
            result_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned   rand_start;
        int unsigned   r;
        int unsigned   lo;
        int unsigned   hi;
        logic [31:0]   flen;
        logic [31:0]   tlen;
        fill_t         fill;
        cfg_t          new_min;
        cfg_t          new_max;
        string         close_how;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_MIN_LEN;
        cfg_data          = '0;
        stream_if.valid   = 1'b0;
        stream_if.in_byte = '0;
        result_if.ready   = 1'b0;
        errors            = 0;
        bytes_sent        = 0;
        frames_sent       = 0;
        results_seen      = 0;
        stall_left        = 0;
        calm              = 1'b0;
        status_override   = ST_BUSY;
        link_closed       = 1'b0;
        min_len           = 31'd10;
        max_len           = 31'd67108864;
        clear_frame();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed-in closing status where it is obvious.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                settle();
                write_limits(cfg_t'(plan[i].len), cfg_t'(plan[i].tlen));
            end
            else
            begin
                status_override = plan[i].want;
                build_frame(plan[i].len, plan[i].tlen, plan[i].fill, 1'b1, 1'b0);
                send_frame();
                status_override = ST_BUSY;
            end
        end

        // Random frames, mostly well-formed; about two in five carry a bad T.
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                settle();
                r       = $urandom_range(0, 3);
                new_min = (r == 0) ? 31'd0 : (r == 1) ? 31'd4 : 31'($urandom_range(0, 12));
                r       = $urandom_range(0, 3);
                new_max = (r == 0) ? 31'h7FFF_FFFF : (r == 1) ? 31'd67108864 :
                          31'($urandom_range(300, 32'h7FFF_FFFF));
                write_limits(new_min, new_max);
            end
            lo   = (min_len < HDR) ? HDR : min_len;
            hi   = ($urandom_range(0, 9) == 0) ? 260 : 48;
            flen = $urandom_range(lo, hi);
            r    = $urandom_range(0, 9);
            case (r)
                0:       tlen = 32'd0;
                1:       tlen = flen - 32'd8 + $urandom_range(1, 50);
                2:       tlen = {1'b1, 31'($urandom)};
                3:       tlen = $urandom;
                default: tlen = (flen >= 32'd9) ? $urandom_range(1, flen - 8) : 32'd1;
            endcase
            r    = $urandom_range(0, 9);
            fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RAND;
            build_frame(flen, tlen, fill, 1'b1, 1'b0);
            send_frame();
        end

        // Close the link one way or another, then show it stays silent.
        calm = 1'b0;
        settle();
        r = $urandom_range(0, 4);
        case (r)
            0:
            begin
                close_how = "negative length";
                write_limits(31'd0, 31'h7FFF_FFFF);
                build_frame(32'h8000_0000 | $urandom, 32'd0, FILL_RAND, 1'b1, 1'b1);
            end
            1:
            begin
                close_how = "length below minimum";
                write_limits(31'd10, 31'd1000);
                build_frame($urandom_range(4, 9), 32'd0, FILL_RAND, 1'b1, 1'b1);
            end
            2:
            begin
                close_how = "length above maximum";
                write_limits(31'd0, 31'd100);
                build_frame($urandom_range(101, 5000), 32'd0, FILL_RAND, 1'b1, 1'b1);
            end
            3:
            begin
                close_how = "length shorter than the trailer";
                write_limits(31'd0, 31'h7FFF_FFFF);
                build_frame($urandom_range(0, 3), 32'd0, FILL_RAND, 1'b1, 1'b1);
            end
            default:
            begin
                close_how = "checksum mismatch";
                write_limits(31'd4, 31'd1000);
                flen = $urandom_range(9, 40);
                build_frame(flen, $urandom_range(1, flen - 8), FILL_RAND, 1'b0, 1'b0);
            end
        endcase
        status_override = (r == 4) ? ST_BAD_SUM : ST_BAD_LEN;
        send_frame();
        status_override = ST_BUSY;
        build_frame(32'd16, 32'd5, FILL_RAND, 1'b1, 1'b0);
        send_frame();
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom));

        settle();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d result requests never arrived", pending_results.size()));

        $display("covered %0d frames, %0d stream bytes, %0d result requests checked",
                 frames_sent, bytes_sent, results_seen);
        $display("limits varied from 0 to 2^31-1; link closed at the end by %s", close_how);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : typed_frame_deframer_adler32_test

`default_nettype wire

// File: typed_frame_deframer_adler32.f
rtl/tfd_pkg.sv
rtl/tfd_ifs.sv
rtl/tfd_adler.sv
rtl/typed_frame_deframer_adler32.sv
tb/typed_frame_deframer_adler32_test.sv
